// File: hdl/hbp_pkg.sv
package hbp_pkg;

   // fixed point one and full six sector hue span
   localparam logic [15:0] ONE_FX   = 16'hFFFF;
   localparam logic [19:0] HUE_FULL = 20'h60000;
   localparam logic [31:0] HALF_DN  = 32'd32767;
   localparam logic [31:0] HALF_UP  = 32'd32768;

   // register map
   localparam logic [0:0] REG_ALPHA_SCALES = 1'b0;

   // hue base sector codes
   localparam logic [2:0] HBASE_RED   = 3'd0;
   localparam logic [2:0] HBASE_GREEN = 3'd2;
   localparam logic [2:0] HBASE_BLUE  = 3'd4;

   typedef struct packed {
      logic [15:0] mix_factor;
      logic [15:0] base_red;
      logic [15:0] base_green;
      logic [15:0] base_blue;
      logic [15:0] base_alpha;
      logic [15:0] blend_red;
      logic [15:0] blend_green;
      logic [15:0] blend_blue;
      logic [15:0] blend_alpha;
   } in_type;

   typedef struct packed {
      logic [15:0] out_red;
      logic [15:0] out_green;
      logic [15:0] out_blue;
      logic [15:0] out_alpha;
   } out_type;

   // per pixel state carried down the pipeline
   typedef struct packed {
      logic [15:0] v;
      logic [31:0] prodv;
      logic [15:0] br;
      logic [15:0] bg;
      logic [15:0] bb;
      logic [15:0] ba;
      logic [15:0] mxb;
      logic [15:0] mnb;
      logic        gray;
      logic        neg;
      logic [2:0]  hbase;
      logic [2:0]  sector;
      logic [15:0] frac;
      logic [15:0] spread;
      logic [31:0] dprod;
      logic [15:0] rr;
      logic [15:0] rg;
      logic [15:0] rb;
      logic [31:0] pa_r;
      logic [31:0] pa_g;
      logic [31:0] pa_b;
      logic [31:0] pb_r;
      logic [31:0] pb_g;
      logic [31:0] pb_b;
      logic [31:0] s_r;
      logic [31:0] s_g;
      logic [31:0] s_b;
   } work_type;

   // floor(x / 65535) by reciprocal estimate and remainder correction
   function automatic logic [15:0] div65535(input logic [31:0] x);
      logic [32:0] e;
      logic [16:0] q0;
      logic [16:0] q1;
      logic [33:0] r;
      e  = {1'b0, x} + {17'b0, x[31:16]};
      q0 = e[32:16];
      r  = {2'b0, x} - {1'b0, q0, 16'b0} + {17'b0, q0};
      if (r >= 34'd131070) begin
         q1 = q0 + 17'd2;
      end else if (r >= 34'd65535) begin
         q1 = q0 + 17'd1;
      end else begin
         q1 = q0;
      end
      return q1[15:0];
   endfunction

endpackage

// File: hdl/hue_blend_pixel.sv
// channel  | ports                                   | direction
// config   | psel penable pwrite paddr pwdata prdata | in/out, apb style, pready tied high
// pixel in | start busy req_data                     | in, taken when start and not busy
// pixel out| rsp_valid rsp_data                      | out, one cycle strobe per pixel
//
// one pixel enters every cycle, busy is never raised
// most of the pipeline is the 17 stage hue divider
// no receiver stall: each result is shown for exactly one cycle
// synchronous reset clears the valid chain and the register
module hue_blend_pixel
   import hbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   input  logic        start,
   output logic        busy,
   input  in_type      req_data,
   output logic        rsp_valid,
   output out_type     rsp_data
);

   logic        mode_ff;
   logic        v1_ff, v2_ff, v3_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff;
   in_type      in_ff;
   work_type    w2_ff, w2_in, w3_ff, w3_in;
   work_type    wc_ff, wc_in, wd_ff, wd_in, we_ff, we_in, wf_ff, wf_in, wg_ff, wg_in;
   out_type     out_ff, out_in;
   logic [15:0] num2_ff, num2_in, dl2_ff, dl2_in, num3_ff, dl3_ff;
   logic        div_valid;
   logic [16:0] div_q;
   work_type    div_side;

   // config register
   assign pready = 1'b1;
   assign busy   = 1'b0;
   assign prdata = (paddr[2] == REG_ALPHA_SCALES) ? {31'b0, mode_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (psel && penable && pwrite && paddr[2] == REG_ALPHA_SCALES) begin
         mode_ff <= pwdata[0];
      end
   end

   // blend hue setup, base extremes, factor product
   always_comb begin
      logic [15:0] mx, mn, hi, lo;
      mx = in_ff.blend_red;
      if (in_ff.blend_green > mx) mx = in_ff.blend_green;
      if (in_ff.blend_blue > mx) mx = in_ff.blend_blue;
      mn = in_ff.blend_red;
      if (in_ff.blend_green < mn) mn = in_ff.blend_green;
      if (in_ff.blend_blue < mn) mn = in_ff.blend_blue;
      w2_in = '0;
      if (in_ff.blend_red == mx) begin
         hi = in_ff.blend_green; lo = in_ff.blend_blue; w2_in.hbase = HBASE_RED;
      end else if (in_ff.blend_green == mx) begin
         hi = in_ff.blend_blue; lo = in_ff.blend_red; w2_in.hbase = HBASE_GREEN;
      end else begin
         hi = in_ff.blend_red; lo = in_ff.blend_green; w2_in.hbase = HBASE_BLUE;
      end
      w2_in.neg   = hi < lo;
      num2_in     = (hi < lo) ? (lo - hi) : (hi - lo);
      dl2_in      = mx - mn;
      w2_in.gray  = (mx == mn);
      w2_in.v     = in_ff.mix_factor;
      w2_in.prodv = in_ff.mix_factor * in_ff.blend_alpha + HALF_DN;
      w2_in.br    = in_ff.base_red;
      w2_in.bg    = in_ff.base_green;
      w2_in.bb    = in_ff.base_blue;
      w2_in.ba    = in_ff.base_alpha;
      w2_in.mxb   = in_ff.base_red;
      if (in_ff.base_green > w2_in.mxb) w2_in.mxb = in_ff.base_green;
      if (in_ff.base_blue > w2_in.mxb) w2_in.mxb = in_ff.base_blue;
      w2_in.mnb   = in_ff.base_red;
      if (in_ff.base_green < w2_in.mnb) w2_in.mnb = in_ff.base_green;
      if (in_ff.base_blue < w2_in.mnb) w2_in.mnb = in_ff.base_blue;
   end

   // mix factor, scaled by blend alpha when the mode bit is set
   always_comb begin
      w3_in = w2_ff;
      if (mode_ff) w3_in.v = div65535(w2_ff.prodv);
   end

   hbp_hue_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_num    (num3_ff),
      .in_dl     (dl3_ff),
      .in_side   (w3_ff),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_side  (div_side)
   );

   // hue position, sector and fraction, base spread
   always_comb begin
      logic [19:0] h;
      wc_in = div_side;
      h = {1'b0, div_side.hbase, 16'b0}
          + (div_side.neg ? (HUE_FULL - {3'b0, div_q}) : {3'b0, div_q});
      if (h >= HUE_FULL) h = h - HUE_FULL;
      wc_in.sector = h[18:16];
      wc_in.frac   = h[15:0];
      wc_in.spread = div_side.mxb - div_side.mnb;
   end

   // spread times fraction
   always_comb begin
      wd_in = wc_ff;
      wd_in.dprod = wc_ff.spread * wc_ff.frac + HALF_UP;
   end

   // recolor by sector
   always_comb begin
      logic [15:0] d, up, dn;
      we_in = wd_ff;
      d  = wd_ff.dprod[31:16];
      up = wd_ff.mnb + d;
      dn = wd_ff.mxb - d;
      case (wd_ff.sector)
         3'd0: begin we_in.rr = wd_ff.mxb; we_in.rg = up; we_in.rb = wd_ff.mnb; end
         3'd1: begin we_in.rr = dn; we_in.rg = wd_ff.mxb; we_in.rb = wd_ff.mnb; end
         3'd2: begin we_in.rr = wd_ff.mnb; we_in.rg = wd_ff.mxb; we_in.rb = up; end
         3'd3: begin we_in.rr = wd_ff.mnb; we_in.rg = dn; we_in.rb = wd_ff.mxb; end
         3'd4: begin we_in.rr = up; we_in.rg = wd_ff.mnb; we_in.rb = wd_ff.mxb; end
         default: begin we_in.rr = wd_ff.mxb; we_in.rg = wd_ff.mnb; we_in.rb = dn; end
      endcase
   end

   // mix products
   always_comb begin
      logic [15:0] iv;
      wf_in = we_ff;
      iv = ONE_FX - we_ff.v;
      wf_in.pa_r = iv * we_ff.br;
      wf_in.pa_g = iv * we_ff.bg;
      wf_in.pa_b = iv * we_ff.bb;
      wf_in.pb_r = we_ff.v * we_ff.rr;
      wf_in.pb_g = we_ff.v * we_ff.rg;
      wf_in.pb_b = we_ff.v * we_ff.rb;
   end

   // mix sums
   always_comb begin
      wg_in = wf_ff;
      wg_in.s_r = wf_ff.pa_r + wf_ff.pb_r + HALF_DN;
      wg_in.s_g = wf_ff.pa_g + wf_ff.pb_g + HALF_DN;
      wg_in.s_b = wf_ff.pa_b + wf_ff.pb_b + HALF_DN;
   end

   // normalize, gray blend passes base through
   always_comb begin
      out_in.out_alpha = wg_ff.ba;
      if (wg_ff.gray) begin
         out_in.out_red   = wg_ff.br;
         out_in.out_green = wg_ff.bg;
         out_in.out_blue  = wg_ff.bb;
      end else begin
         out_in.out_red   = div65535(wg_ff.s_r);
         out_in.out_green = div65535(wg_ff.s_g);
         out_in.out_blue  = div65535(wg_ff.s_b);
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         vc_ff <= 1'b0; vd_ff <= 1'b0; ve_ff <= 1'b0;
         vf_ff <= 1'b0; vg_ff <= 1'b0; vh_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff; v3_ff <= v2_ff;
         vc_ff <= div_valid; vd_ff <= vc_ff; ve_ff <= vd_ff;
         vf_ff <= ve_ff; vg_ff <= vf_ff; vh_ff <= vg_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (start && !busy) in_ff <= req_data;
      w2_ff   <= w2_in;
      num2_ff <= num2_in;
      dl2_ff  <= dl2_in;
      w3_ff   <= w3_in;
      num3_ff <= num2_ff;
      dl3_ff  <= dl2_ff;
      wc_ff   <= wc_in;
      wd_ff   <= wd_in;
      we_ff   <= we_in;
      wf_ff   <= wf_in;
      wg_ff   <= wg_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = vh_ff;
   assign rsp_data  = out_ff;

   // hue sector stays inside the six sectors
   a_sector: assert property (@(posedge clock) disable iff (reset)
      vc_ff |-> wc_ff.sector <= 3'd5)
      else $error("hue sector out of range");

   // recolor stays at or below base maximum, red also at or above base minimum
   a_recolor: assert property (@(posedge clock) disable iff (reset)
      ve_ff |-> (we_ff.rr <= we_ff.mxb && we_ff.rr >= we_ff.mnb
                 && we_ff.rg <= we_ff.mxb && we_ff.rb <= we_ff.mxb))
      else $error("recolor outside base range");

   // gray blend color gives the base red and blue back
   a_gray: assert property (@(posedge clock) disable iff (reset)
      vg_ff && wg_ff.gray |=> rsp_valid && rsp_data.out_red == $past(wg_ff.br)
                              && rsp_data.out_blue == $past(wg_ff.bb))
      else $error("gray blend did not pass base through");

endmodule

// File: hdl/hbp_hue_div.sv
// restoring divider, one quotient bit per stage:
// q = (num * 65536 + dl / 2) / dl with num <= dl
module hbp_hue_div
   import hbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [15:0] in_num,
   input  logic [15:0] in_dl,
   input  work_type    in_side,
   output logic        out_valid,
   output logic [16:0] out_q,
   output work_type    out_side
);

   localparam int STAGES = 17;

   logic [16:0] rem_ff  [0:STAGES-1];
   logic [16:0] quo_ff  [0:STAGES-1];
   logic [15:0] dl_ff   [0:STAGES-1];
   work_type    side_ff [0:STAGES-1];
   logic        vld_ff  [0:STAGES-1];

   genvar k;
   generate
      for (k = 0; k < STAGES; k++) begin : g_stage
         logic [16:0] trial;
         logic [16:0] quo_prev;
         logic [15:0] dl_cur;
         logic        ge;
         logic [16:0] rem_in;
         logic [16:0] quo_in;

         // shift in the next bit of the rounding half
         if (k == 0) begin : g_first
            assign trial    = {1'b0, in_num};
            assign quo_prev = 17'd0;
            assign dl_cur   = in_dl;
         end else begin : g_next
            logic [16:0] dlx;
            assign dlx      = {1'b0, dl_ff[k-1]};
            assign trial    = {rem_ff[k-1][15:0], dlx[STAGES-k]};
            assign quo_prev = quo_ff[k-1];
            assign dl_cur   = dl_ff[k-1];
         end

         assign ge     = trial >= {1'b0, dl_cur};
         assign rem_in = ge ? (trial - {1'b0, dl_cur}) : trial;

         always_comb begin
            quo_in = quo_prev;
            quo_in[STAGES-1-k] = ge;
         end

         // stage registers
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k-1];
            end
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            dl_ff[k]   <= dl_cur;
            side_ff[k] <= (k == 0) ? in_side : side_ff[(k == 0) ? 0 : k-1];
         end
      end
   endgenerate

   assign out_valid = vld_ff[STAGES-1];
   assign out_q     = quo_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule
